### rtl/sida_pkg.sv
package sida_pkg;

    localparam int VALUE_W       = 32;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_W       = 4;
    localparam int NUM_DIGITS    = 10;
    localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
    localparam int BITS_PER_STEP = 2;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);
    localparam int IDX_W         = $clog2(NUM_DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_bcd;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the value, clear the BCD word
        logic conv;        // run one shift-add-3 step
        logic find_lead;   // locate the most significant nonzero digit
        logic emit_sign;   // send '-'
        logic emit_digit;  // send the digit at the current index, step down
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_done;
        logic negative;
        logic idx_zero;
    } t_dp_status;

endpackage

### rtl/signed_int_to_decimal_ascii.sv
// Converts one signed 32-bit integer to its decimal ASCII text, most
// significant character first: a leading '-' for negative values, no leading
// zeros, a single '0' for zero, and the most negative value printed in full.
// Pulse start while busy is low to transfer a value; busy then stays high
// until the final digit has been issued. Each character appears on
// o_char_code for exactly one cycle with o_strobe high, and o_last marks the
// final character. The receiver cannot stall: it must take every character
// in the cycle it is shown. The magnitude runs through a shift-add-3
// binary-to-BCD unit two bits per cycle, the leading digit is then located,
// then one character leaves per cycle. A value yields 1 to 11 characters.
// Busy covers the conversion, the search and the issue of every character,
// and a new value is taken only once busy is low again. Characters follow
// the conversion back to back.
module signed_int_to_decimal_ascii (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [sida_pkg::VALUE_W-1:0]  i_value,
    output logic                          busy,
    output logic                          o_strobe,
    output logic [sida_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);

    // Command and status between sequencer and datapath.
    sida_pkg::t_dp_cmd    cmd;
    sida_pkg::t_dp_status status;

    // Sequence load, conversion, leading-digit search and character issue.
    sida_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Hold the magnitude, BCD word and output character register.
    sida_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

### rtl/sida_datapath.sv
module sida_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [sida_pkg::VALUE_W-1:0]    i_value,
    input  sida_pkg::t_dp_cmd               i_cmd,
    output sida_pkg::t_dp_status            o_status,
    output logic                            o_strobe,
    output logic [sida_pkg::CHAR_W-1:0]     o_char_code,
    output logic                            o_last
);

    logic [sida_pkg::VALUE_W-1:0] r_mag;
    sida_pkg::t_bcd               r_bcd;
    logic                         r_neg;
    logic [sida_pkg::STEP_W-1:0]  r_step;
    logic [sida_pkg::IDX_W-1:0]   r_idx;
    logic                         r_strobe;
    logic [sida_pkg::CHAR_W-1:0]  r_char;
    logic                         r_last;

    sida_pkg::t_bcd               n_bcd;
    logic [sida_pkg::VALUE_W-1:0] n_mag;
    logic [sida_pkg::IDX_W-1:0]   n_lead;

    // One double-dabble bit: correct digits of five and up, then shift in.
    function automatic sida_pkg::t_bcd dabble_bit(input sida_pkg::t_bcd bcd,
                                                  input logic in_bit);
        sida_pkg::t_bcd             adj;
        logic [sida_pkg::BCD_W-1:0] flat;
        for (int d = 0; d < sida_pkg::NUM_DIGITS; d++) begin
            adj[d] = (bcd[d] >= 4'd5) ? bcd[d] + 4'd3 : bcd[d];
        end
        flat = {adj[sida_pkg::NUM_DIGITS-1:0]};
        flat = {flat[sida_pkg::BCD_W-2:0], in_bit};
        return sida_pkg::t_bcd'(flat);
    endfunction

    always_comb begin
        n_bcd = r_bcd;
        n_mag = r_mag;
        for (int b = 0; b < sida_pkg::BITS_PER_STEP; b++) begin
            n_bcd = dabble_bit(n_bcd, n_mag[sida_pkg::VALUE_W-1]);
            n_mag = {n_mag[sida_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    always_comb begin
        n_lead = '0;
        for (int d = 0; d < sida_pkg::NUM_DIGITS; d++) begin
            if (r_bcd[d] != '0) begin
                n_lead = sida_pkg::IDX_W'(d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg  <= i_value[sida_pkg::VALUE_W-1];
            r_mag  <= i_value[sida_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;
            r_bcd  <= '0;
            r_step <= '0;
        end else if (i_cmd.conv) begin
            r_mag  <= n_mag;
            r_bcd  <= n_bcd;
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.find_lead) begin
            r_idx <= n_lead;
        end else if (i_cmd.emit_digit) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.emit_sign) begin
            r_char <= sida_pkg::CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= sida_pkg::CHAR_ZERO + {4'b0, r_bcd[r_idx]};
            r_last <= (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_sign | i_cmd.emit_digit;
        end
    end

    assign o_status.conv_done = (r_step == sida_pkg::STEP_W'(sida_pkg::CONV_STEPS - 1));
    assign o_status.negative  = r_neg;
    assign o_status.idx_zero  = (r_idx == '0);

    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

### rtl/sida_ctrl.sv
module sida_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  sida_pkg::t_dp_status i_status,
    output sida_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_LEAD,
        S_SIGN,
        S_DIGIT
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   accept;

    assign accept = i_start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CONV;
                        r_busy  <= 1'b1;
                    end
                end
                S_CONV: begin
                    if (i_status.conv_done) begin
                        r_state <= S_LEAD;
                    end
                end
                S_LEAD: begin
                    r_state <= i_status.negative ? S_SIGN : S_DIGIT;
                end
                S_SIGN: begin
                    r_state <= S_DIGIT;
                end
                S_DIGIT: begin
                    if (i_status.idx_zero) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && accept;
        o_cmd.conv       = (r_state == S_CONV);
        o_cmd.find_lead  = (r_state == S_LEAD);
        o_cmd.emit_sign  = (r_state == S_SIGN);
        o_cmd.emit_digit = (r_state == S_DIGIT);
    end

    assign o_busy = r_busy;

endmodule

### rtl/sida_checker.sv
module sida_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_strobe,
    input logic [sida_pkg::CHAR_W-1:0]  o_char_code,
    input logic                         o_last
);

    // Only '-' or a decimal digit leaves the block.
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_char_code == sida_pkg::CHAR_MINUS) ||
                     ((o_char_code >= sida_pkg::CHAR_ZERO) &&
                      (o_char_code <= sida_pkg::CHAR_ZERO + 8'd9)))
        else $error("illegal character issued");

    // A transfer in raises busy on the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    // Characters before the final one only appear while busy.
    a_busy_covers_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("character outside a busy run");

    // A minus sign is never final and is followed at once by a digit.
    a_minus_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_char_code == sida_pkg::CHAR_MINUS)) |->
            !o_last ##1 (o_strobe && (o_char_code != sida_pkg::CHAR_MINUS)))
        else $error("minus sign not followed by a digit");

    // The final character ends the run: no character in the next cycle.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("character right after final character");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_HALF     = 6;       // 12 ns period
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 290;
    localparam int QUIET_TAIL   = 40;      // last transfers go out with no idling
    localparam int SETTLE_WAIT  = 40;      // longer than one full conversion
    localparam int CYCLE_LIMIT  = 200000;  // slowest correct run stays well under this limit
    localparam logic [sida_pkg::VALUE_W-1:0] RADIX = 10;

    // Directed values: digit-count boundaries, both signs, the most negative
    // value and its neighbor, zero and alternating bit patterns.
    localparam logic [sida_pkg::VALUE_W-1:0] EDGE_VALUES [20] = '{
        32'd0,          32'd1,           -32'sd1,          32'd9,
        -32'sd9,        32'd10,          -32'sd10,         32'd99,
        32'd100,        32'h7FFF_FFFF,   32'h8000_0000,    32'h8000_0001,
        32'd999999999,  32'd1000000000,  -32'sd999999999,  -32'sd1000000000,
        32'd1234567890, -32'sd1234567890, 32'hAAAA_AAAA,   32'h5555_5555
    };

    typedef struct {
        logic [sida_pkg::VALUE_W-1:0] value;
        bit                           drain;   // hold this transfer until all text is out
    } t_conv_req;

    typedef struct {
        logic [sida_pkg::CHAR_W-1:0] char_code;
        logic                        last;
    } t_text_char;

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start   = 1'b0;
    logic [sida_pkg::VALUE_W-1:0] i_value = '0;
    logic                         busy;
    logic                         o_strobe;
    logic [sida_pkg::CHAR_W-1:0]  o_char_code;
    logic                         o_last;

    t_conv_req  pending_values[$];   // values not yet transferred
    t_text_char expected_text[$];    // characters still owed by the block

    int error_count    = 0;
    int idle_left      = 0;
    int idle_mode      = 0;   // 0: no idling, 1: sparse bursts, 2: dense bursts
    int accepted_count = 0;
    int cycle_count    = 0;

    signed_int_to_decimal_ascii i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_value     (i_value),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Append the decimal text of one value to the expected characters:
    // optional '-', then the digits of the unsigned magnitude, most
    // significant first, with last set on the final digit only.
    function automatic void predict_text(input logic [sida_pkg::VALUE_W-1:0] value);
        logic [sida_pkg::VALUE_W-1:0] magnitude;
        logic [sida_pkg::DIGIT_W-1:0] digits [sida_pkg::NUM_DIGITS];
        int                           count;
        t_text_char                   ch;
        // Two's complement negate in 32 bits; the most negative value maps
        // to 2147483648 as an unsigned magnitude.
        magnitude = value[sida_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
        count = 0;
        // Zero still yields a single digit.
        do begin
            digits[count] = sida_pkg::DIGIT_W'(magnitude % RADIX);
            magnitude     = magnitude / RADIX;
            count++;
        end while (magnitude != 0);
        if (value[sida_pkg::VALUE_W-1]) begin
            ch.char_code = sida_pkg::CHAR_MINUS;
            ch.last      = 1'b0;
            expected_text.push_back(ch);
        end
        for (int k = count - 1; k >= 0; k--) begin
            ch.char_code = sida_pkg::CHAR_ZERO + digits[k];
            ch.last      = (k == 0);
            expected_text.push_back(ch);
        end
    endfunction

    // Pick a random operand: full-range bit patterns, values near zero, or a
    // value with a random digit count so every text length shows up often.
    function automatic logic [sida_pkg::VALUE_W-1:0] random_operand();
        int unsigned                  pick;
        int unsigned                  ndigits;
        int unsigned                  lo;
        int unsigned                  hi;
        logic [sida_pkg::VALUE_W-1:0] magnitude;
        pick = $urandom_range(99, 0);
        if (pick < 40)
            return $urandom();
        if (pick < 50)
            return $urandom_range(40, 0) - 20;
        ndigits = $urandom_range(10, 1);
        lo = 1;
        repeat (ndigits - 1) lo = lo * 10;
        hi = (ndigits == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
        if (ndigits == 1)
            lo = 0;
        magnitude = $urandom_range(hi, lo);
        return $urandom_range(1, 0) ? -magnitude : magnitude;
    endfunction

    // Driver: a transfer happens at an edge where start is high and busy is
    // low. Hold start and the value until then; after each transfer either
    // present the next value right away or idle for a random burst first.
    always @(posedge i_clk) begin : drive_proc
        t_conv_req req;
        bit        accepted;
        if (i_rst_n) begin
            accepted = start && !busy;
            if (accepted) begin
                predict_text(i_value);
                accepted_count++;
                // Change the idling pattern now and then, so that some
                // stretches run back to back and others are full of gaps.
                if (accepted_count % 50 == 0)
                    idle_mode = $urandom_range(2, 0);
            end
            if (!start || accepted) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (pending_values.size() == 0 ||
                             (pending_values[0].drain && expected_text.size() != 0)) begin
                    // Nothing left, or wait for the block to empty its text.
                    start <= 1'b0;
                end else if (pending_values.size() > QUIET_TAIL && idle_mode != 0 &&
                             $urandom_range(idle_mode == 1 ? 5 : 1, 0) == 0) begin
                    // Start an idle burst, with start held low from here.
                    idle_left = $urandom_range(9, 1) - 1;
                    start <= 1'b0;
                end else begin
                    req = pending_values.pop_front();
                    start   <= 1'b1;
                    i_value <= req.value;
                end
            end
        end
    end

    // Monitor: every strobed character must match the oldest one owed.
    always @(posedge i_clk) begin : check_proc
        t_text_char want;
        if (i_rst_n && o_strobe) begin
            if (expected_text.size() == 0) begin
                $error("unexpected character 0x%02h (last %b)", o_char_code, o_last);
                error_count++;
            end else begin
                want = expected_text.pop_front();
                if (o_char_code !== want.char_code) begin
                    $error("char_code mismatch: expected 0x%02h, actual 0x%02h",
                           want.char_code, o_char_code);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last mismatch: expected %b, actual %b", want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Guard against a hung block or a missing character.
    always @(posedge i_clk) begin : watchdog_proc
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("signed_int_to_decimal_ascii test failed");
            $finish;
        end
    end

    initial begin : stimulus_proc
        t_conv_req req;
        // Directed part first; the first one also waits for an empty block.
        foreach (EDGE_VALUES[i]) begin
            req.value = EDGE_VALUES[i];
            req.drain = (i == 0);
            pending_values.push_back(req);
        end
        // Random part; drain fully before its first value and at a few
        // random points after that.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            req.value = random_operand();
            req.drain = (n == 0) || ($urandom_range(49, 0) == 0);
            pending_values.push_back(req);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last transfer, then for all of its text.
        while (pending_values.size() != 0 || start)
            @(posedge i_clk);
        while (expected_text.size() != 0)
            @(posedge i_clk);
        // Leave time for any stray character to show up.
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (error_count == 0 && expected_text.size() == 0)
            $display("signed_int_to_decimal_ascii test passed");
        else
            $display("signed_int_to_decimal_ascii test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/sida_pkg.sv
rtl/sida_datapath.sv
rtl/sida_ctrl.sv
rtl/signed_int_to_decimal_ascii.sv
rtl/sida_checker.sv
bench/testbench.sv
